// ===== rtl/pn2d_pkg.sv =====
`timescale 1ns / 1ps
package pn2d_pkg;
  localparam int ONE_Q16 = 65536;
  localparam int SAT_HI = 131071;
  localparam int SAT_LO = -131072;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // image and lattice geometry, sized to fit the 9-bit coordinate and 11-bit index fields
  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int CELL_SIZE    = 8;
  localparam int CELL_COLUMNS = 32;

  // round half up by 2^n, then saturate to 18-bit signed
  function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
    if (v > 48'sd131071) return 18'sd131071;
    if (v < -48'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
    logic signed [47:0] u;
    u = v + 48'sd32768;
    return u >>> 16;
  endfunction

  function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] u;
    u = v + 48'sd8192;
    return u >>> 14;
  endfunction

  function automatic logic [16:0] clamp_t(input logic signed [47:0] v);
    if (v < 0) return 17'd0;
    if (v > 48'sd65536) return 17'd65536;
    return v[16:0];
  endfunction
endpackage

// ===== rtl/perlin_noise_2d_point_core.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the pipeline advances; load beats go straight to the table and give no result.
// The pipeline advances when the output register is empty or being taken.
// Reset (rst, synchronous) clears the valid bits; the gradient table is not cleared
// and must be loaded before it is read.
module perlin_noise_2d_point_core import pn2d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: entry_index[10:0], grad_x[26:11], grad_y[42:27], x_coord[51:43],
  //        y_coord[60:52], zero pad [63:61]
  input  logic [63:0] s_tdata,
  // tuser: req_type
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: noise[17:0], zero pad [23:18]
  output logic [23:0] m_tdata
);
  localparam int ROWS  = IMAGE_HEIGHT / CELL_SIZE + 1;
  localparam int DEPTH = (CELL_COLUMNS + 1) * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NST   = 9;

  logic [10:0]        entry_index;
  logic signed [15:0] grad_x, grad_y;
  logic [8:0]         x_coord, y_coord;
  assign entry_index = s_tdata[10:0];
  assign grad_x = s_tdata[26:11];
  assign grad_y = s_tdata[42:27];
  assign x_coord = s_tdata[51:43];
  assign y_coord = s_tdata[60:52];

  logic adv;
  logic [NST-1:0] vld;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // four table copies, one per corner
  logic [31:0] mem0 [DEPTH];
  logic [31:0] mem1 [DEPTH];
  logic [31:0] mem2 [DEPTH];
  logic [31:0] mem3 [DEPTH];
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == REQ_LOAD && 32'(entry_index) < DEPTH) begin
      mem0[entry_index[AW-1:0]] <= {grad_y, grad_x};
      mem1[entry_index[AW-1:0]] <= {grad_y, grad_x};
      mem2[entry_index[AW-1:0]] <= {grad_y, grad_x};
      mem3[entry_index[AW-1:0]] <= {grad_y, grad_x};
    end
  end

  // stage 1: locate cell and fractions
  function automatic void locate(input int c, input int size, output int cell_idx,
                                 output logic [16:0] t);
    int cc, base;
    cc = (c > size) ? size : c;
    base = (cc == size) ? size - CELL_SIZE : cc - cc % CELL_SIZE;
    if (base < 0) base = 0;
    cell_idx = base / CELL_SIZE;
    t = clamp_t(48'(((cc - base) * ONE_Q16 + CELL_SIZE / 2) / CELL_SIZE));
  endfunction

  logic [16:0] tx1, ty1, uy1;
  logic [AW-1:0] i00, i10, i01, i11;
  logic        ok00, ok10, ok01, ok11;
  always_ff @(posedge clk) begin
    int cx, cy, ix;
    logic [16:0] tx, ty;
    if (adv) begin
      locate(int'(x_coord), IMAGE_WIDTH, cx, tx);
      locate(int'(y_coord), IMAGE_HEIGHT, cy, ty);
      tx1 <= tx; ty1 <= ty;
      ix = cx + (CELL_COLUMNS + 1) * cy;
      i00 <= AW'(ix); ok00 <= ix < DEPTH;
      i10 <= AW'(ix + 1); ok10 <= ix + 1 < DEPTH;
      i01 <= AW'(ix + CELL_COLUMNS + 1); ok01 <= ix + CELL_COLUMNS + 1 < DEPTH;
      i11 <= AW'(ix + CELL_COLUMNS + 2); ok11 <= ix + CELL_COLUMNS + 2 < DEPTH;
    end
  end

  // distance from the upper row
  assign uy1 = 17'(ONE_Q16) - ty1;

  // stage 2: table read; fade first products
  logic [31:0] e00, e10, e01, e11;
  logic        k00, k10, k01, k11;
  logic [16:0] tx2, ty2, uy2;
  logic signed [20:0] ax2, ay2;
  logic [32:0] at2, au2;
  always_ff @(posedge clk) begin
    if (adv) begin
      e00 <= mem0[i00]; k00 <= ok00;
      e10 <= mem1[i10]; k10 <= ok10;
      e01 <= mem2[i01]; k01 <= ok01;
      e11 <= mem3[i11]; k11 <= ok11;
      tx2 <= tx1; ty2 <= ty1; uy2 <= uy1;
      ax2 <= 21'sd6 * $signed({4'd0, tx1}) - 21'sd983040;
      at2 <= {16'd0, tx1} * {16'd0, tx1};
      ay2 <= 21'sd6 * $signed({4'd0, uy1}) - 21'sd983040;
      au2 <= {16'd0, uy1} * {16'd0, uy1};
    end
  end

  // stage 3: corner dots; fade a*t, t2
  logic signed [17:0] bl, br, tl, tr;
  logic [16:0] tx3, uy3;
  logic signed [20:0] bx3, by3;
  logic [16:0] t2x3, t2y3;
  function automatic logic signed [17:0] dot(input logic [31:0] e, input logic k,
      input logic signed [17:0] ox, input logic signed [17:0] oy);
    logic signed [15:0] gx, gy;
    logic signed [33:0] px, py;
    gx = k ? e[15:0] : 16'sd0;
    gy = k ? e[31:16] : 16'sd0;
    px = 34'(gx) * 34'(ox);
    py = 34'(gy) * 34'(oy);
    return sat18(rnd14(48'(px) + 48'(py)));
  endfunction
  always_ff @(posedge clk) begin
    logic signed [17:0] ox0, oy0, ox1, oy1;
    logic signed [38:0] fa_x, fa_y;
    if (adv) begin
      ox0 = $signed({1'b0, tx2}); oy0 = $signed({1'b0, ty2});
      ox1 = ox0 - 18'sd65536; oy1 = oy0 - 18'sd65536;
      bl <= dot(e00, k00, ox0, oy0);
      br <= dot(e10, k10, ox1, oy0);
      tl <= dot(e01, k01, ox0, oy1);
      tr <= dot(e11, k11, ox1, oy1);
      tx3 <= tx2; uy3 <= uy2;
      fa_x = 39'(ax2) * 39'($signed({1'b0, tx2}));
      fa_y = 39'(ay2) * 39'($signed({1'b0, uy2}));
      bx3 <= 21'(rnd16(48'(fa_x)) + 48'sd655360);
      by3 <= 21'(rnd16(48'(fa_y)) + 48'sd655360);
      t2x3 <= 17'(rnd16(48'($signed({1'b0, at2}))));
      t2y3 <= 17'(rnd16(48'($signed({1'b0, au2}))));
    end
  end

  // stage 4: t3
  logic signed [17:0] bl4, br4, tl4, tr4;
  logic signed [20:0] bx4, by4;
  logic [16:0] t3x4, t3y4;
  always_ff @(posedge clk) begin
    logic [33:0] sq_x, sq_y;
    if (adv) begin
      bl4 <= bl; br4 <= br; tl4 <= tl; tr4 <= tr;
      bx4 <= bx3; by4 <= by3;
      sq_x = {17'd0, t2x3} * {17'd0, tx3};
      sq_y = {17'd0, t2y3} * {17'd0, uy3};
      t3x4 <= 17'(rnd16(48'($signed({1'b0, sq_x}))));
      t3y4 <= 17'(rnd16(48'($signed({1'b0, sq_y}))));
    end
  end

  // stage 5: fade weights
  logic signed [17:0] bl5, br5, tl5, tr5;
  logic [16:0] wx5, wy5;
  always_ff @(posedge clk) begin
    logic signed [38:0] fw_x, fw_y;
    if (adv) begin
      bl5 <= bl4; br5 <= br4; tl5 <= tl4; tr5 <= tr4;
      fw_x = 39'(bx4) * 39'($signed({1'b0, t3x4}));
      fw_y = 39'(by4) * 39'($signed({1'b0, t3y4}));
      wx5 <= clamp_t(rnd16(48'(fw_x)));
      wy5 <= clamp_t(rnd16(48'(fw_y)));
    end
  end

  // stage 6: x products
  logic signed [17:0] bl6, tl6;
  logic signed [36:0] pb6, pt6;
  logic [16:0] wy6;
  always_ff @(posedge clk) begin
    logic signed [18:0] db, dt;
    if (adv) begin
      bl6 <= bl5; tl6 <= tl5; wy6 <= wy5;
      db = 19'(br5) - 19'(bl5);
      dt = 19'(tr5) - 19'(tl5);
      pb6 <= 37'($signed({1'b0, wx5})) * 37'(db);
      pt6 <= 37'($signed({1'b0, wx5})) * 37'(dt);
    end
  end

  // stage 7: x lerps
  logic signed [17:0] bot7, top7;
  logic [16:0] wy7;
  always_ff @(posedge clk) begin
    if (adv) begin
      bot7 <= sat18(48'(bl6) + rnd16(48'(pb6)));
      top7 <= sat18(48'(tl6) + rnd16(48'(pt6)));
      wy7 <= wy6;
    end
  end

  // stage 8: y product
  logic signed [17:0] top8;
  logic signed [36:0] p8;
  always_ff @(posedge clk) begin
    logic signed [18:0] dv;
    if (adv) begin
      top8 <= top7;
      dv = 19'(bot7) - 19'(top7);
      p8 <= 37'($signed({1'b0, wy7})) * 37'(dv);
    end
  end

  // stage 9: final lerp and scale into the output register
  always_ff @(posedge clk) begin
    logic signed [47:0] v, r;
    if (adv) begin
      v = 48'(sat18(48'(top8) + rnd16(48'(p8))));
      r = (v + 48'sd65536 + 48'sd1) >>> 1;
      m_tdata <= {6'd0, sat18(r)};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid && s_tuser == REQ_EVAL};
    end
  end
  assign m_tvalid = vld[NST-1];
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pn2d_pkg::*;

  localparam int IMG_W     = 256;
  localparam int IMG_H     = 256;
  localparam int CELL      = 8;
  localparam int COLS      = 32;
  localparam int GRID_ROWS = IMG_H / CELL + 1;
  localparam int GRID_SIZE = (COLS + 1) * GRID_ROWS;
  localparam int LATENCY   = 9;
  // lattice rows loaded at the top and at the bottom of the image
  localparam int BAND_ROWS = 4;
  localparam int LOW_Y_MAX = (BAND_ROWS - 1) * CELL - 1;
  localparam int HIGH_Y_MIN = (GRID_ROWS - BAND_ROWS) * CELL;

  typedef struct {
    logic        kind;
    logic [10:0] idx;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [8:0]  px;
    logic [8:0]  py;
  } noise_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  noise_req_t        req_queue[$];
  noise_req_t        held_req;
  logic signed [17:0] noise_expect[$];
  logic [31:0]       grad_mem [GRID_SIZE];
  int                src_gap = 0;
  int                sink_gap = 0;
  bit                burst_mode = 1'b0;
  int                errors = 0;
  int                n_loads = 0;
  int                n_evals = 0;
  int                n_noise = 0;

  perlin_noise_2d_point_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- fixed point predictor ----
  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fade_q16(longint t);
    longint a, b, t2, t3;
    a  = 6 * t - 15 * longint'(ONE_Q16);
    b  = ((a * t + 32768) >>> 16) + 10 * longint'(ONE_Q16);
    t2 = (t * t + 32768) >>> 16;
    t3 = (t2 * t + 32768) >>> 16;
    return clip((b * t3 + 32768) >>> 16, 0, ONE_Q16);
  endfunction

  function automatic longint grad_dot(longint cx, longint cy, longint ox, longint oy);
    longint idx, gx, gy;
    logic [31:0] e;
    idx = cx + (COLS + 1) * cy;
    e = '0;
    if (idx < GRID_SIZE) e = grad_mem[idx];
    gx = longint'($signed(e[15:0]));
    gy = longint'($signed(e[31:16]));
    return clip((gx * ox + gy * oy + 8192) >>> 14, SAT_LO, SAT_HI);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return clip(a + ((w * (b - a) + 32768) >>> 16), SAT_LO, SAT_HI);
  endfunction

  // lattice cell and Q.16 fraction along one axis
  task automatic find_cell(input longint c, input longint size,
                           output longint cell_idx, output longint t);
    longint base;
    if (c > size) c = size;
    if (c == size) base = size - CELL;
    else base = c - c % CELL;
    if (base < 0) base = 0;
    cell_idx = base / CELL;
    t = clip(((c - base) * ONE_Q16 + CELL / 2) / CELL, 0, ONE_Q16);
  endtask

  task automatic predict_noise(input noise_req_t r);
    longint cx, cy, tx, ty, bl, br, tl, tr, wx, wy, top, bot, v;
    if (r.kind == REQ_LOAD) begin
      if (r.idx < GRID_SIZE) grad_mem[r.idx] = {r.gy, r.gx};
      n_loads++;
    end else begin
      find_cell(longint'(r.px), IMG_W, cx, tx);
      find_cell(longint'(r.py), IMG_H, cy, ty);
      bl  = grad_dot(cx, cy, tx, ty);
      br  = grad_dot(cx + 1, cy, tx - ONE_Q16, ty);
      tl  = grad_dot(cx, cy + 1, tx, ty - ONE_Q16);
      tr  = grad_dot(cx + 1, cy + 1, tx - ONE_Q16, ty - ONE_Q16);
      wx  = fade_q16(tx);
      top = blend(tl, tr, wx);
      bot = blend(bl, br, wx);
      wy  = fade_q16(ONE_Q16 - ty);
      v   = blend(top, bot, wy);
      noise_expect.push_back(18'(clip((v + ONE_Q16 + 1) >>> 1, SAT_LO, SAT_HI)));
      n_evals++;
    end
  endtask

  // mostly short gaps, now and then a long one, with bursts of none
  function automatic int idle_len();
    if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
    if (burst_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---- source driver ----
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_noise(held_req);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          held_req = req_queue.pop_front();
          s_tdata  <= {3'b000, held_req.py, held_req.px, held_req.gy, held_req.gx,
                       held_req.idx};
          s_tuser  <= held_req.kind;
          s_tvalid <= 1'b1;
          src_gap  = idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_noise++;
        if (noise_expect.size() == 0) begin
          report_mismatch("unexpected noise beat", $signed(m_tdata[17:0]), 0);
        end else begin
          if ($signed(m_tdata[17:0]) !== noise_expect[0])
            report_mismatch("noise", $signed(m_tdata[17:0]), noise_expect[0]);
          void'(noise_expect.pop_front());
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap = idle_len();
      end
    end
  end

  task automatic add_load(input int idx, input int gx, input int gy);
    noise_req_t r;
    r = '{REQ_LOAD, 11'(idx), 16'(gx), 16'(gy), 9'($urandom), 9'($urandom)};
    req_queue.push_back(r);
  endtask

  task automatic add_eval(input int x, input int y);
    noise_req_t r;
    r = '{REQ_EVAL, 11'($urandom), 16'($urandom), 16'($urandom), 9'(x), 9'(y)};
    req_queue.push_back(r);
  endtask

  function automatic int rand_grad();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // y inside the loaded rows, top or bottom of the image
  function automatic int band_y();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, LOW_Y_MAX));
    return int'($urandom_range(HIGH_Y_MIN, IMG_H));
  endfunction

  initial begin
    int k;
    for (k = 0; k < GRID_SIZE; k++) grad_mem[k] = '0;
    // edge rows first, so no corner is ever read unwritten
    for (k = 0; k < BAND_ROWS * (COLS + 1); k++) add_load(k, rand_grad(), rand_grad());
    for (k = (GRID_ROWS - BAND_ROWS) * (COLS + 1); k < GRID_SIZE; k++)
      add_load(k, rand_grad(), rand_grad());

    // directed: extreme gradients, out of range index, edge coordinates
    add_load(0, 16384, 16384);
    add_load(1, -16384, 16384);
    add_load(33, 16384, -16384);
    add_load(34, -16384, -16384);
    add_load(GRID_SIZE - 1, 32767, -32768);
    add_load(2047, 0, 0);
    add_load(1100, 1, 1);
    add_eval(0, 0);
    add_eval(3, 5);
    add_eval(4, 4);
    add_eval(7, 7);
    add_eval(8, 8);
    add_eval(255, 0);
    add_eval(256, 0);
    add_eval(0, 256);
    add_eval(256, 256);
    add_eval(511, 511);
    add_eval(300, 17);
    add_eval(255, 255);
    add_load(GRID_SIZE - 2, -32768, 32767);
    add_eval(252, 252);
    add_eval(256, 255);

    // random mix
    for (k = 0; k < 120; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 7) == 0) add_load($urandom_range(0, 2047), rand_grad(), rand_grad());
        else add_load($urandom_range(0, GRID_SIZE - 1), rand_grad(), rand_grad());
      end else if ($urandom_range(0, 9) == 0) begin
        add_eval($urandom_range(0, 511), $urandom_range(HIGH_Y_MIN, 511));
      end else begin
        add_eval($urandom_range(0, IMG_W), band_y());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (req_queue.size() > 0 || s_tvalid || noise_expect.size() > 0) @(posedge clk);
    repeat (LATENCY * 3) @(posedge clk);

    $display("covered %0d gradient loads and %0d noise evaluations, %0d results checked",
             n_loads, n_evals, n_noise);
    if (errors == 0 && noise_expect.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", noise_expect.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
